>>> hdl/swg_pkg.sv
package swg_pkg;

  // Fixed-point set-up
  localparam int FRAC_BITS = 14;
  localparam int VLEN      = 4;
  localparam int OUT_FRAC  = 12;
  localparam int X_W       = 16;
  localparam int OUT_W     = 16;

  // Weight width: |w| <= 0.5, so FRAC_BITS+1 bits hold it with a spare bit
  localparam int W_W   = FRAC_BITS + 1;
  // h1, h3 and silu stay near the raw input scale (|h| <= ~1.05 * 2^15)
  localparam int H_W   = 18;
  // gated product g = silu*h3 / 2^FRAC_BITS
  localparam int G_W   = 2 * H_W - FRAC_BITS - 3;
  // projection product and 4-term sum
  localparam int PRD_W = W_W + G_W;
  localparam int ACC_W = PRD_W + 2;
  // 4*sig lies in 0 .. 2^(FRAC_BITS+2), held as a non-negative signed value
  localparam int S4_W  = FRAC_BITS + 4;
  localparam int SP_W  = H_W + S4_W;
  localparam int GP_W  = 2 * H_W;
  // final rounding shift to Q3.12
  localparam int OSH   = 2 * FRAC_BITS - OUT_FRAC;

  // register stages: 2 (gate/linear proj) + 4 (SiLU, gating) + 2 (down proj) + 1 (out)
  localparam int NSTG  = 9;

  typedef logic signed [W_W-1:0] wgt_t;
  typedef logic signed [G_W-1:0] vin_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic en_mul;
    logic en_sum;
  } proj_ctl_t;

  // constant in hundredths -> round(c * 2^FRAC_BITS / 100), half away from zero
  function automatic wgt_t qw(input int c100);
    longint num;
    longint mag;
    num = longint'(c100) <<< FRAC_BITS;
    if (num >= 0) begin
      mag = (num + 50) / 100;
      return W_W'(mag);
    end else begin
      mag = (50 - num) / 100;
      return W_W'(-mag);
    end
  endfunction

  localparam wgt_t W1_Q [VLEN][VLEN] = '{
    '{qw( 40), qw(-20), qw( 15), qw( 30)},
    '{qw(-25), qw( 50), qw( 10), qw(-15)},
    '{qw( 30), qw( 10), qw(-35), qw( 20)},
    '{qw(-10), qw(-30), qw( 45), qw(  5)}
  };

  localparam wgt_t W3_Q [VLEN][VLEN] = '{
    '{qw( 35), qw( 10), qw(-20), qw( 25)},
    '{qw(  5), qw(-40), qw( 30), qw( 10)},
    '{qw(-15), qw( 20), qw( 40), qw(-10)},
    '{qw( 20), qw( 30), qw( -5), qw(-35)}
  };

  localparam wgt_t W2_Q [VLEN][VLEN] = '{
    '{qw( 45), qw(-15), qw( 20), qw( 10)},
    '{qw(-20), qw( 35), qw( 10), qw(-25)},
    '{qw( 10), qw( 20), qw(-40), qw( 30)},
    '{qw(-30), qw(  5), qw( 25), qw( 45)}
  };

endpackage

>>> hdl/swg_proj.sv
// 4x4 constant-weight projection: product stage, then sum stage.
module swg_proj (
  input  logic                clk,
  input  swg_pkg::proj_ctl_t  ctl,
  input  swg_pkg::wgt_t       w [swg_pkg::VLEN][swg_pkg::VLEN],
  input  swg_pkg::vin_t       v [swg_pkg::VLEN],
  output swg_pkg::acc_t       acc [swg_pkg::VLEN]
);

  logic signed [swg_pkg::PRD_W-1:0] prod_r [swg_pkg::VLEN][swg_pkg::VLEN];
  swg_pkg::acc_t                    acc_nxt [swg_pkg::VLEN];
  swg_pkg::acc_t                    acc_r [swg_pkg::VLEN];

  always_ff @(posedge clk) begin
    if (ctl.en_mul) begin
      for (int i = 0; i < swg_pkg::VLEN; i++) begin
        for (int j = 0; j < swg_pkg::VLEN; j++) begin
          prod_r[i][j] <= swg_pkg::PRD_W'(w[i][j]) * swg_pkg::PRD_W'(v[j]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < swg_pkg::VLEN; i++) begin
      acc_nxt[i] = '0;
      for (int j = 0; j < swg_pkg::VLEN; j++) begin
        acc_nxt[i] = acc_nxt[i] + swg_pkg::ACC_W'(prod_r[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_sum) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

>>> hdl/swiglu_mlp_4x4.sv
// SwiGLU feed-forward block, fixed 4x4 weights. One beat on the input carries a
// token vector x0..x3 in signed Q1.14; one beat on the output carries out0..out3
// in signed Q3.12, saturated to the 16-bit range. The result is
// W2 * (silu(W1*x) * (W3*x)) with silu(z) = z * clip(0.25z + 0.5, 0, 1), all
// weights rounded to Q1.14 and every internal rounding done as round half up.
// Any 16-bit input pattern is valid; only the outputs saturate. The datapath is
// a nine-stage pipeline (gate/linear products, sums, round, sigmoid product,
// gating product, round, down-projection products, sums, round and saturate);
// with out_ready held high one vector is taken every cycle. Each stage
// carries its own valid bit and moves only when the stage after it is empty
// or moving, so bubbles close up and a held out_ready stalls the pipe without
// loss. No configuration, no state between vectors.
module swiglu_mlp_4x4 (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_x0,
  input  logic [15:0] in_x1,
  input  logic [15:0] in_x2,
  input  logic [15:0] in_x3,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_out0,
  output logic [15:0] out_out1,
  output logic [15:0] out_out2,
  output logic [15:0] out_out3
);

  localparam int F     = swg_pkg::FRAC_BITS;
  localparam int VLEN  = swg_pkg::VLEN;
  localparam int H_W   = swg_pkg::H_W;
  localparam int G_W   = swg_pkg::G_W;
  localparam int ACC_W = swg_pkg::ACC_W;
  localparam int S4_W  = swg_pkg::S4_W;
  localparam int SP_W  = swg_pkg::SP_W;
  localparam int GP_W  = swg_pkg::GP_W;
  localparam int NSTG  = swg_pkg::NSTG;
  localparam int OSH   = swg_pkg::OSH;
  localparam int OUT_W = swg_pkg::OUT_W;

  // rounding offsets (add half, then arithmetic shift = round half up)
  localparam logic signed [ACC_W:0] HALF_H   = (ACC_W+1)'(1) <<< (F - 1);
  localparam logic signed [ACC_W:0] HALF_O   = (ACC_W+1)'(1) <<< (OSH - 1);
  localparam logic signed [SP_W:0]  HALF_SIL = (SP_W+1)'(1) <<< (F + 1);
  localparam logic signed [GP_W:0]  HALF_G   = (GP_W+1)'(1) <<< (F - 1);
  // sigmoid offset 0.5 and ceiling 1.0, both scaled by 4
  localparam logic signed [H_W:0]   S4_OFS   = (H_W+1)'(1) <<< (F + 1);
  localparam logic signed [H_W:0]   S4_TOP   = (H_W+1)'(1) <<< (F + 2);
  // Q3.12 output limits
  localparam logic signed [ACC_W:0] OUT_MAX  = (ACC_W+1)'((1 <<< (OUT_W - 1)) - 1);
  localparam logic signed [ACC_W:0] OUT_MIN  = -((ACC_W+1)'(1) <<< (OUT_W - 1));

  // ---------------------------------------------------------------- flow control
  // Stage k loads when it is empty or its contents move on this edge.
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NSTG-1];

  // ------------------------------------------------- stages 0-1: h1/h3 projections
  swg_pkg::vin_t      x_ext [VLEN];
  swg_pkg::acc_t      acc1 [VLEN];
  swg_pkg::acc_t      acc3 [VLEN];
  swg_pkg::proj_ctl_t ctl13;

  assign x_ext[0] = G_W'($signed(in_x0));
  assign x_ext[1] = G_W'($signed(in_x1));
  assign x_ext[2] = G_W'($signed(in_x2));
  assign x_ext[3] = G_W'($signed(in_x3));

  assign ctl13.en_mul = en[0];
  assign ctl13.en_sum = en[1];

  swg_proj u_proj_w1 (
    .clk (clk),
    .ctl (ctl13),
    .w   (swg_pkg::W1_Q),
    .v   (x_ext),
    .acc (acc1)
  );

  swg_proj u_proj_w3 (
    .clk (clk),
    .ctl (ctl13),
    .w   (swg_pkg::W3_Q),
    .v   (x_ext),
    .acc (acc3)
  );

  // ---------------------------------------------------- stage 2: round to Q.14
  logic signed [ACC_W:0] r1 [VLEN];
  logic signed [ACC_W:0] r3 [VLEN];
  logic signed [H_W-1:0] h1_nxt [VLEN];
  logic signed [H_W-1:0] h3_nxt [VLEN];
  logic signed [H_W-1:0] h1_r [VLEN];
  logic signed [H_W-1:0] h3_r [VLEN];

  always_comb begin
    for (int i = 0; i < VLEN; i++) begin
      r1[i]     = (ACC_W+1)'(acc1[i]) + HALF_H;
      r3[i]     = (ACC_W+1)'(acc3[i]) + HALF_H;
      h1_nxt[i] = H_W'(r1[i] >>> F);
      h3_nxt[i] = H_W'(r3[i] >>> F);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      h1_r <= h1_nxt;
      h3_r <= h3_nxt;
    end
  end

  // ------------------------------------- stage 3: 4*sig = clip(h1 + 2, 0, 4); h1*4sig
  logic signed [H_W:0]    s4_raw [VLEN];
  logic signed [S4_W-1:0] s4 [VLEN];
  logic signed [SP_W-1:0] sp_r [VLEN];
  logic signed [H_W-1:0]  h3_d_r [VLEN];

  always_comb begin
    for (int i = 0; i < VLEN; i++) begin
      s4_raw[i] = (H_W+1)'(h1_r[i]) + S4_OFS;
      if (s4_raw[i] < 0) begin
        s4[i] = '0;
      end else if (s4_raw[i] > S4_TOP) begin
        s4[i] = S4_W'(S4_TOP);
      end else begin
        s4[i] = S4_W'(s4_raw[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < VLEN; i++) begin
        sp_r[i] <= SP_W'(h1_r[i]) * SP_W'(s4[i]);
      end
      h3_d_r <= h3_r;
    end
  end

  // --------------------------------------------------- stage 4: silu, silu*h3
  logic signed [SP_W:0]   sil_rnd [VLEN];
  logic signed [H_W-1:0]  silu [VLEN];
  logic signed [GP_W-1:0] gp_r [VLEN];

  always_comb begin
    for (int i = 0; i < VLEN; i++) begin
      sil_rnd[i] = (SP_W+1)'(sp_r[i]) + HALF_SIL;
      silu[i]    = H_W'(sil_rnd[i] >>> (F + 2));
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < VLEN; i++) begin
        gp_r[i] <= GP_W'(silu[i]) * GP_W'(h3_d_r[i]);
      end
    end
  end

  // ------------------------------------------------------ stage 5: round g
  logic signed [GP_W:0] g_rnd [VLEN];
  swg_pkg::vin_t        g_nxt [VLEN];
  swg_pkg::vin_t        g_r [VLEN];

  always_comb begin
    for (int i = 0; i < VLEN; i++) begin
      g_rnd[i] = (GP_W+1)'(gp_r[i]) + HALF_G;
      g_nxt[i] = G_W'(g_rnd[i] >>> F);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      g_r <= g_nxt;
    end
  end

  // ------------------------------------------------ stages 6-7: down projection
  swg_pkg::acc_t      acc2 [VLEN];
  swg_pkg::proj_ctl_t ctl2;

  assign ctl2.en_mul = en[6];
  assign ctl2.en_sum = en[7];

  swg_proj u_proj_w2 (
    .clk (clk),
    .ctl (ctl2),
    .w   (swg_pkg::W2_Q),
    .v   (g_r),
    .acc (acc2)
  );

  // ------------------------------------ stage 8: round to Q3.12 and saturate
  logic signed [ACC_W:0]   o_rnd [VLEN];
  logic signed [ACC_W:0]   o_sh [VLEN];
  logic signed [OUT_W-1:0] o_nxt [VLEN];
  logic signed [OUT_W-1:0] o_r [VLEN];

  always_comb begin
    for (int i = 0; i < VLEN; i++) begin
      o_rnd[i] = (ACC_W+1)'(acc2[i]) + HALF_O;
      o_sh[i]  = o_rnd[i] >>> OSH;
      if (o_sh[i] > OUT_MAX) begin
        o_nxt[i] = OUT_W'(OUT_MAX);
      end else if (o_sh[i] < OUT_MIN) begin
        o_nxt[i] = OUT_W'(OUT_MIN);
      end else begin
        o_nxt[i] = OUT_W'(o_sh[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      o_r <= o_nxt;
    end
  end

  assign out_out0 = o_r[0];
  assign out_out1 = o_r[1];
  assign out_out2 = o_r[2];
  assign out_out3 = o_r[3];

  // ---------------------------------------------------------------- checks
  // an empty output stage never holds back the input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with output stage empty");

  // a full pipe facing a stalled sink must refuse new beats
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(v_r) == NSTG) && !out_ready |-> !in_ready)
    else $error("beat accepted into a full stalled pipe");

  // vectors in flight change only by accepted input and output beats
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> ($countones(v_r) == $past($countones(v_r))
                + ($past(in_valid && in_ready) ? 1 : 0)
                - ($past(out_valid && out_ready) ? 1 : 0)))
    else $error("vector lost or duplicated in pipe");

  // reset empties every stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (v_r == '0))
    else $error("stage valid left set after reset");

endmodule

>>> bench/swiglu_ffn_checker.sv
module swiglu_ffn_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] in_x0,
  input  logic [15:0] in_x1,
  input  logic [15:0] in_x2,
  input  logic [15:0] in_x3,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_out0,
  input  logic [15:0] out_out1,
  input  logic [15:0] out_out2,
  input  logic [15:0] out_out3,
  output int          fails,
  output int          due_cnt,
  output int          n_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [swg_pkg::VLEN-1:0][15:0] vec16_t;

  // weights in hundredths, row i feeds element i
  localparam int W1_C [swg_pkg::VLEN][swg_pkg::VLEN] = '{
    '{ 40, -20,  15,  30}, '{-25,  50,  10, -15},
    '{ 30,  10, -35,  20}, '{-10, -30,  45,   5}};
  localparam int W3_C [swg_pkg::VLEN][swg_pkg::VLEN] = '{
    '{ 35,  10, -20,  25}, '{  5, -40,  30,  10},
    '{-15,  20,  40, -10}, '{ 20,  30,  -5, -35}};
  localparam int W2_C [swg_pkg::VLEN][swg_pkg::VLEN] = '{
    '{ 45, -15,  20,  10}, '{-20,  35,  10, -25},
    '{ 10,  20, -40,  30}, '{-30,   5,  25,  45}};

  vec16_t ffn_due_q [$];
  vec16_t exp_v;
  vec16_t got_v;
  int     fail_tally = 0;
  int     due_now    = 0;
  int     done_tally = 0;

  assign fails     = fail_tally;
  assign due_cnt   = due_now;
  assign n_checked = done_tally;

  // hundredths -> Q1.FRAC_BITS, nearest, halves away from zero
  function automatic longint q_weight(input int c100);
    longint num;
    num = longint'(c100) * (64'sd1 <<< swg_pkg::FRAC_BITS);
    if (num >= 0) return (num + 50) / 100;
    return -((50 - num) / 100);
  endfunction

  // add half, then floor
  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic vec16_t swiglu_ffn(input vec16_t x_in);
    longint xv [swg_pkg::VLEN];
    longint h1 [swg_pkg::VLEN];
    longint h3 [swg_pkg::VLEN];
    longint g  [swg_pkg::VLEN];
    longint acc1, acc3, s4, silu, r;
    vec16_t y;
    int i, j;
    for (i = 0; i < swg_pkg::VLEN; i++) xv[i] = longint'($signed(x_in[i]));
    for (i = 0; i < swg_pkg::VLEN; i++) begin
      acc1 = 0;
      acc3 = 0;
      for (j = 0; j < swg_pkg::VLEN; j++) begin
        acc1 += q_weight(W1_C[i][j]) * xv[j];
        acc3 += q_weight(W3_C[i][j]) * xv[j];
      end
      h1[i] = rnd_shift(acc1, swg_pkg::FRAC_BITS);
      h3[i] = rnd_shift(acc3, swg_pkg::FRAC_BITS);
    end
    // 4*sig = clip(h1 + 2.0, 0, 4.0)
    for (i = 0; i < swg_pkg::VLEN; i++) begin
      s4 = h1[i] + (64'sd1 <<< (swg_pkg::FRAC_BITS + 1));
      if (s4 < 0) s4 = 0;
      if (s4 > (64'sd1 <<< (swg_pkg::FRAC_BITS + 2))) begin
        s4 = 64'sd1 <<< (swg_pkg::FRAC_BITS + 2);
      end
      silu = rnd_shift(h1[i] * s4, swg_pkg::FRAC_BITS + 2);
      g[i] = rnd_shift(silu * h3[i], swg_pkg::FRAC_BITS);
    end
    for (i = 0; i < swg_pkg::VLEN; i++) begin
      acc1 = 0;
      for (j = 0; j < swg_pkg::VLEN; j++) acc1 += q_weight(W2_C[i][j]) * g[j];
      r = rnd_shift(acc1, 2 * swg_pkg::FRAC_BITS - swg_pkg::OUT_FRAC);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      y[i] = r[15:0];
    end
    return y;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got_v = {out_out3, out_out2, out_out1, out_out0};
        if (ffn_due_q.size() == 0) begin
          $error("result beat with nothing expected: %h %h %h %h",
                 out_out0, out_out1, out_out2, out_out3);
          fail_tally++;
        end else begin
          exp_v = ffn_due_q.pop_front();
          for (int k = 0; k < swg_pkg::VLEN; k++) begin
            if (got_v[k] !== exp_v[k]) begin
              $error("out%0d: expected %0d, got %0d", k,
                     $signed(exp_v[k]), $signed(got_v[k]));
              fail_tally++;
            end
          end
          done_tally++;
        end
      end
      if (in_valid && in_ready)
        ffn_due_q.push_back(swiglu_ffn({in_x3, in_x2, in_x1, in_x0}));
      due_now <= ffn_due_q.size();
    end
  end

endmodule

>>> bench/tb_swiglu_mlp_4x4.sv
module tb_swiglu_mlp_4x4;
  timeunit 1ns;
  timeprecision 1ps;

  // no beat either way for this many cycles means the block has hung
  localparam int WDOG_LIMIT = 3000;
  // receiver hold-off, long enough to back the whole pipe up into in_ready
  localparam int LONG_HOLD  = 300;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_x0, in_x1, in_x2, in_x3;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_out0, out_out1, out_out2, out_out3;

  int fails, due_cnt, n_checked;
  int n_sent     = 0;
  int idle_run   = 0;
  int n_holdoffs = 0;

  // stimulus shaping flags, shared between sender and receiver
  bit quiet      = 1'b0;   // last part of the run: nobody idles
  bit burst_gaps = 1'b1;   // sender may insert idle bursts
  bit long_hold  = 1'b0;   // request for one long receiver hold-off

  always #5 clk = ~clk;

  swiglu_mlp_4x4 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_x0     (in_x0),
    .in_x1     (in_x1),
    .in_x2     (in_x2),
    .in_x3     (in_x3),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_out0  (out_out0),
    .out_out1  (out_out1),
    .out_out2  (out_out2),
    .out_out3  (out_out3)
  );

  swiglu_ffn_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_x0     (in_x0),
    .in_x1     (in_x1),
    .in_x2     (in_x2),
    .in_x3     (in_x3),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_out0  (out_out0),
    .out_out1  (out_out1),
    .out_out2  (out_out2),
    .out_out3  (out_out3),
    .fails     (fails),
    .due_cnt   (due_cnt),
    .n_checked (n_checked)
  );

  // Offer one beat and hold it until the block takes it. Any idle burst
  // comes first, so in_valid is never dropped and raised in one step.
  // Returns in the step of the accepting edge without touching in_valid.
  task automatic send_beat(input logic [15:0] a, b, c, d);
    if (!quiet && burst_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x0    <= a;
    in_x1    <= b;
    in_x2    <= c;
    in_x3    <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  // Mostly nominal-range values, some full 16-bit patterns (out-of-range
  // inputs are legal), some corner codes to hit the sigmoid clip regions.
  function automatic logic [15:0] rand_elem();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 11) return 16'($urandom_range(0, 32768) - 16384);
    if (pick < 16) return 16'($urandom);
    case ($urandom_range(0, 6))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h4000;
      3: return 16'hC000;
      4: return 16'hFFFF;
      5: return 16'h0001;
      default: return 16'h0000;
    endcase
  endfunction

  task automatic send_random(input int n);
    for (int k = 0; k < n; k++)
      send_beat(rand_elem(), rand_elem(), rand_elem(), rand_elem());
  endtask

  // Stop offering until every expected result has come back.
  task automatic drain_pause();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_cnt != 0);
  endtask

  // Receiver: random ready stretches, random stall bursts, one long
  // hold-off on request, and ready held high in the quiet part.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
        n_holdoffs++;
      end else if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Watchdog: counts cycles with no beat on either channel.
  initial begin
    while (idle_run < WDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("tb_swiglu_mlp_4x4: errors");
    $finish;
  end

  initial begin
    in_valid = 1'b0;
    in_x0    = '0;
    in_x1    = '0;
    in_x2    = '0;
    in_x3    = '0;
    rst_n    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero, the nominal and raw extremes, one-hot vectors
    send_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_beat(16'h4000, 16'h4000, 16'h4000, 16'h4000);
    send_beat(16'hC000, 16'hC000, 16'hC000, 16'hC000);
    send_beat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_beat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_beat(16'h4000, 16'h0000, 16'h0000, 16'h0000);
    send_beat(16'h0000, 16'h4000, 16'h0000, 16'h0000);
    send_beat(16'h0000, 16'h0000, 16'h4000, 16'h0000);
    send_beat(16'h0000, 16'h0000, 16'h0000, 16'h4000);
    send_beat(16'hC000, 16'h0000, 16'h0000, 16'h0000);
    send_beat(16'h0000, 16'hC000, 16'h0000, 16'h0000);
    send_beat(16'h0000, 16'h0000, 16'hC000, 16'h0000);
    send_beat(16'h0000, 16'h0000, 16'h0000, 16'hC000);
    // out-of-range inputs matched to row signs: gate 0 past +2.0 (sigmoid
    // saturates at one) and past -2.0 (sigmoid clipped to zero)
    send_beat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_beat(16'h8000, 16'h7FFF, 16'h8000, 16'h8000);
    // gate 1 sits right on the clip knees
    send_beat(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_beat(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    // smallest steps and checkerboards
    send_beat(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF);
    send_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(16'h4000, 16'hC000, 16'h4000, 16'hC000);
    send_beat(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);

    send_random(300);

    // long receiver hold-off while beats keep coming back to back, so the
    // pipe fills and in_ready has to drop
    long_hold  = 1'b1;
    burst_gaps = 1'b0;
    send_random(60);
    burst_gaps = 1'b1;

    drain_pause();
    send_random(300);
    drain_pause();

    // last part: full rate, no idling on either side
    quiet = 1'b1;
    send_random(240);

    in_valid <= 1'b0;
    do @(posedge clk); while (due_cnt != 0);
    // catch any stray beat the pipe might still push out
    repeat (2 * swg_pkg::NSTG) @(posedge clk);

    $display("%0d vectors sent, %0d result beats checked field by field",
             n_sent, n_checked);
    $display("%0d long receiver hold-off(s), sigmoid clip regions and raw extremes covered",
             n_holdoffs);
    if (fails == 0 && due_cnt == 0) begin
      $display("tb_swiglu_mlp_4x4: clean");
    end else begin
      $display("tb_swiglu_mlp_4x4: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/swg_pkg.sv
hdl/swg_proj.sv
hdl/swiglu_mlp_4x4.sv
bench/swiglu_ffn_checker.sv
bench/tb_swiglu_mlp_4x4.sv
